// File: rtl/sip_pkg.sv
// Package for the segment intersection point block: widths, types and outcome codes.
// Depends on nothing; used by rtl/segment_intersection_point.sv.
package sip_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 32;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int LO_W    = CROSS_W / 2;
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int SUM_W   = CROSS_W + DIFF_W + 1;
    localparam int QUO_W   = COORD_BITS + FRAC_BITS;
    localparam int NUM_W   = SUM_W + FRAC_BITS;
    localparam int EXT_W   = (QUO_W + 1 > OUT_BITS) ? QUO_W + 2 : OUT_BITS + 1;
    localparam int PPH_W   = DIFF_W + HI_W;
    localparam int PPL_W   = DIFF_W + LO_W + 1;

    localparam logic [1:0] OUTC_HIT      = 2'd0;
    localparam logic [1:0] OUTC_PARALLEL = 2'd1;
    localparam logic [1:0] OUTC_DISJOINT = 2'd2;

    localparam logic [1:0] ORI_COLLINEAR = 2'd0;
    localparam logic [1:0] ORI_POS       = 2'd1;
    localparam logic [1:0] ORI_NEG       = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [PPH_W-1:0]      pph_t;
    typedef logic signed [PPL_W-1:0]      ppl_t;

    function automatic logic [1:0] orient_code(input cross_t v);
        logic [1:0] r;
        if (v == '0) r = ORI_COLLINEAR;
        else if (v[CROSS_W-1]) r = ORI_NEG;
        else r = ORI_POS;
        return r;
    endfunction

endpackage

// File: rtl/segment_intersection_point.sv
// Segment intersection point: exact orientation test and Q.FRAC crossing point, pipelined.
// Depends on rtl/sip_pkg.sv.
//
// Usage. A word of eight signed coordinates (two segments, start and end point
// each) is taken at every rising edge where start is high and busy is low. busy
// is held low: the pipeline accepts one word per clock, every clock.
// Each accepted word yields exactly one result word, shown for one cycle with
// done high: hit, outcome (intersecting, parallel, disjoint), point_x, point_y.
// The receiver cannot stall, so nothing is ever held back inside the block.
//
// Stages in order: one input stage, one product stage, one stage forming the
// cross products and the hit decision, two stages for the numerators (partial
// products, then their sum and the fractional scaling), then one restoring
// division step per quotient bit in QUO_W stages for x and y in parallel, and a
// final stage that applies the sign, saturates and zeroes the point when there
// is no hit. Throughput is one word per cycle; each stage, the division stages
// included, holds one word.
// Reset clears only the valid bits that travel with the data; in-flight words
// are dropped and no result appears until a new word has gone through.
module segment_intersection_point
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] a_end_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_start_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_start_y,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_end_x,
    input  logic signed [sip_pkg::COORD_BITS-1:0] b_end_y,
    output logic                                 done,
    output logic                                 hit,
    output logic [1:0]                           outcome,
    output logic signed [sip_pkg::OUT_BITS-1:0]  point_x,
    output logic signed [sip_pkg::OUT_BITS-1:0]  point_y
);

    localparam int XW = sip_pkg::CROSS_W;
    localparam int QW = sip_pkg::QUO_W;
    localparam int NW = sip_pkg::NUM_W;
    localparam int SW = sip_pkg::SUM_W;
    localparam int EW = sip_pkg::EXT_W;
    localparam int OW = sip_pkg::OUT_BITS;
    localparam int LW = sip_pkg::LO_W;

    assign busy = 1'b0;

    // Stage 1: coordinates and all differences the products need.
    logic s1_v_reg;
    sip_pkg::coord_t ax_reg, ay_reg, qx_reg, qy_reg, bx_reg, by_reg, rx_reg, ry_reg;
    sip_pkg::diff_t dxa_reg, dya_reg, dxb_reg, dyb_reg;
    sip_pkg::diff_t bqx_reg, bqy_reg, rqx_reg, rqy_reg;
    sip_pkg::diff_t arx_reg, ary_reg, qrx_reg, qry_reg, bax_reg, bay_reg;

    function automatic sip_pkg::diff_t dif(input sip_pkg::coord_t p, input sip_pkg::coord_t m);
        return sip_pkg::diff_t'(p) - sip_pkg::diff_t'(m);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= a_start_x;
        ay_reg  <= a_start_y;
        qx_reg  <= a_end_x;
        qy_reg  <= a_end_y;
        bx_reg  <= b_start_x;
        by_reg  <= b_start_y;
        rx_reg  <= b_end_x;
        ry_reg  <= b_end_y;
        dxa_reg <= dif(a_end_x, a_start_x);
        dya_reg <= dif(a_end_y, a_start_y);
        dxb_reg <= dif(b_end_x, b_start_x);
        dyb_reg <= dif(b_end_y, b_start_y);
        bqx_reg <= dif(b_start_x, a_end_x);
        bqy_reg <= dif(b_start_y, a_end_y);
        rqx_reg <= dif(b_end_x, a_end_x);
        rqy_reg <= dif(b_end_y, a_end_y);
        arx_reg <= dif(a_start_x, b_end_x);
        ary_reg <= dif(a_start_y, b_end_y);
        qrx_reg <= dif(a_end_x, b_end_x);
        qry_reg <= dif(a_end_y, b_end_y);
        bax_reg <= dif(b_start_x, a_start_x);
        bay_reg <= dif(b_start_y, a_start_y);
    end

    // Stage 2: the twelve products and the bounding box tests.
    function automatic logic in_box(input sip_pkg::coord_t ex, input sip_pkg::coord_t ey,
                                    input sip_pkg::coord_t px, input sip_pkg::coord_t py,
                                    input sip_pkg::coord_t fx, input sip_pkg::coord_t fy);
        logic okx, oky;
        okx = (ex < fx) ? (px >= ex && px <= fx) : (px >= fx && px <= ex);
        oky = (ey < fy) ? (py >= ey && py <= fy) : (py >= fy && py <= ey);
        return okx & oky;
    endfunction

    logic s2_v_reg;
    sip_pkg::prod_t den1_reg, den2_reg, o1a_reg, o1b_reg, o2a_reg, o2b_reg;
    sip_pkg::prod_t o3a_reg, o3b_reg, o4a_reg, o4b_reg, tn1_reg, tn2_reg;
    logic [3:0] box_reg;
    sip_pkg::coord_t s2_ax_reg, s2_ay_reg;
    sip_pkg::diff_t s2_dxa_reg, s2_dya_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        den1_reg   <= dxa_reg * dyb_reg;
        den2_reg   <= dya_reg * dxb_reg;
        o1a_reg    <= dya_reg * bqx_reg;
        o1b_reg    <= dxa_reg * bqy_reg;
        o2a_reg    <= dya_reg * rqx_reg;
        o2b_reg    <= dxa_reg * rqy_reg;
        o3a_reg    <= dyb_reg * arx_reg;
        o3b_reg    <= dxb_reg * ary_reg;
        o4a_reg    <= dyb_reg * qrx_reg;
        o4b_reg    <= dxb_reg * qry_reg;
        tn1_reg    <= bax_reg * dyb_reg;
        tn2_reg    <= bay_reg * dxb_reg;
        box_reg[0] <= in_box(ax_reg, ay_reg, bx_reg, by_reg, qx_reg, qy_reg);
        box_reg[1] <= in_box(ax_reg, ay_reg, rx_reg, ry_reg, qx_reg, qy_reg);
        box_reg[2] <= in_box(bx_reg, by_reg, ax_reg, ay_reg, rx_reg, ry_reg);
        box_reg[3] <= in_box(bx_reg, by_reg, qx_reg, qy_reg, rx_reg, ry_reg);
        s2_ax_reg  <= ax_reg;
        s2_ay_reg  <= ay_reg;
        s2_dxa_reg <= dxa_reg;
        s2_dya_reg <= dya_reg;
    end

    // Stage 3: cross products, orientation signs and the decision.
    function automatic sip_pkg::cross_t xsub(input sip_pkg::prod_t p, input sip_pkg::prod_t m);
        return sip_pkg::cross_t'(p) - sip_pkg::cross_t'(m);
    endfunction

    sip_pkg::cross_t den_c;
    logic [1:0] d1_c, d2_c, d3_c, d4_c;
    logic meet_c;

    always_comb
    begin
        den_c = xsub(den1_reg, den2_reg);
        d1_c = sip_pkg::orient_code(xsub(o1a_reg, o1b_reg));
        d2_c = sip_pkg::orient_code(xsub(o2a_reg, o2b_reg));
        d3_c = sip_pkg::orient_code(xsub(o3a_reg, o3b_reg));
        d4_c = sip_pkg::orient_code(xsub(o4a_reg, o4b_reg));
        meet_c = (d1_c != d2_c && d3_c != d4_c)
              || (d1_c == sip_pkg::ORI_COLLINEAR && box_reg[0])
              || (d2_c == sip_pkg::ORI_COLLINEAR && box_reg[1])
              || (d3_c == sip_pkg::ORI_COLLINEAR && box_reg[2])
              || (d4_c == sip_pkg::ORI_COLLINEAR && box_reg[3]);
    end

    logic s3_v_reg;
    logic [1:0] s3_outc_reg;
    sip_pkg::cross_t den_reg, tn_reg;
    sip_pkg::coord_t s3_ax_reg, s3_ay_reg;
    sip_pkg::diff_t s3_dxa_reg, s3_dya_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (den_c == '0) s3_outc_reg <= sip_pkg::OUTC_PARALLEL;
        else if (!meet_c) s3_outc_reg <= sip_pkg::OUTC_DISJOINT;
        else s3_outc_reg <= sip_pkg::OUTC_HIT;
        den_reg    <= den_c;
        tn_reg     <= xsub(tn1_reg, tn2_reg);
        s3_ax_reg  <= s2_ax_reg;
        s3_ay_reg  <= s2_ay_reg;
        s3_dxa_reg <= s2_dxa_reg;
        s3_dya_reg <= s2_dya_reg;
    end

    // Stage 4: numerators A*den + dA*tn as partial products over split halves.
    function automatic sip_pkg::pph_t mul_hi(input sip_pkg::diff_t a, input sip_pkg::cross_t c);
        return a * $signed(c[XW-1:LW]);
    endfunction

    function automatic sip_pkg::ppl_t mul_lo(input sip_pkg::diff_t a, input sip_pkg::cross_t c);
        return a * $signed({1'b0, c[LW-1:0]});
    endfunction

    logic s4_v_reg;
    logic [1:0] s4_outc_reg;
    sip_pkg::cross_t s4_den_reg;
    sip_pkg::pph_t xh1_reg, xh2_reg, yh1_reg, yh2_reg;
    sip_pkg::ppl_t xl1_reg, xl2_reg, yl1_reg, yl2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_outc_reg <= s3_outc_reg;
        s4_den_reg  <= den_reg;
        xh1_reg <= mul_hi(sip_pkg::diff_t'(s3_ax_reg), den_reg);
        xl1_reg <= mul_lo(sip_pkg::diff_t'(s3_ax_reg), den_reg);
        xh2_reg <= mul_hi(s3_dxa_reg, tn_reg);
        xl2_reg <= mul_lo(s3_dxa_reg, tn_reg);
        yh1_reg <= mul_hi(sip_pkg::diff_t'(s3_ay_reg), den_reg);
        yl1_reg <= mul_lo(sip_pkg::diff_t'(s3_ay_reg), den_reg);
        yh2_reg <= mul_hi(s3_dya_reg, tn_reg);
        yl2_reg <= mul_lo(s3_dya_reg, tn_reg);
    end

    // Stage 5: sum, sign and magnitude, fractional scaling; seeds the divider.
    function automatic sip_pkg::sum_t join_pp(input sip_pkg::pph_t h, input sip_pkg::ppl_t l);
        return (sip_pkg::sum_t'(h) <<< LW) + sip_pkg::sum_t'(l);
    endfunction

    function automatic logic [NW-1:0] scale_mag(input sip_pkg::sum_t v);
        logic [SW-1:0] m;
        m = v[SW-1] ? SW'(-v) : SW'(v);
        return NW'(m) << sip_pkg::FRAC_BITS;
    endfunction

    sip_pkg::sum_t nx_c, ny_c;
    logic [NW-1:0] nxm_c, nym_c;

    always_comb
    begin
        nx_c  = join_pp(xh1_reg, xl1_reg) + join_pp(xh2_reg, xl2_reg);
        ny_c  = join_pp(yh1_reg, yl1_reg) + join_pp(yh2_reg, yl2_reg);
        nxm_c = scale_mag(nx_c);
        nym_c = scale_mag(ny_c);
    end

    // Division pipeline: index 0 is the seed, index k+1 follows step k.
    logic            dv_v_reg    [0:QW];
    logic [1:0]      dv_outc_reg [0:QW];
    logic            dv_negx_reg [0:QW];
    logic            dv_negy_reg [0:QW];
    logic [XW-1:0]   dv_dm_reg   [0:QW];
    logic [XW-1:0]   dv_rx_reg   [0:QW];
    logic [XW-1:0]   dv_ry_reg   [0:QW];
    logic [QW-1:0]   dv_lx_reg   [0:QW];
    logic [QW-1:0]   dv_ly_reg   [0:QW];
    logic [QW-1:0]   dv_qx_reg   [0:QW];
    logic [QW-1:0]   dv_qy_reg   [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            dv_v_reg[0] <= s4_v_reg;
            for (int k = 0; k < QW; k++)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_outc_reg[0] <= s4_outc_reg;
        dv_negx_reg[0] <= nx_c[SW-1] ^ s4_den_reg[XW-1];
        dv_negy_reg[0] <= ny_c[SW-1] ^ s4_den_reg[XW-1];
        dv_dm_reg[0]   <= s4_den_reg[XW-1] ? XW'(-s4_den_reg) : XW'(s4_den_reg);
        dv_rx_reg[0]   <= XW'(nxm_c >> QW);
        dv_ry_reg[0]   <= XW'(nym_c >> QW);
        dv_lx_reg[0]   <= nxm_c[QW-1:0];
        dv_ly_reg[0]   <= nym_c[QW-1:0];
        dv_qx_reg[0]   <= '0;
        dv_qy_reg[0]   <= '0;
    end

    // One restoring step per stage for each of x and y.
    logic [XW:0] trx_c [0:QW-1];
    logic [XW:0] try_c [0:QW-1];
    logic        gex_c [0:QW-1];
    logic        gey_c [0:QW-1];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trx_c[k] = {dv_rx_reg[k], dv_lx_reg[k][QW-1]};
            try_c[k] = {dv_ry_reg[k], dv_ly_reg[k][QW-1]};
            gex_c[k] = trx_c[k] >= {1'b0, dv_dm_reg[k]};
            gey_c[k] = try_c[k] >= {1'b0, dv_dm_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QW; k++)
        begin
            dv_outc_reg[k+1] <= dv_outc_reg[k];
            dv_negx_reg[k+1] <= dv_negx_reg[k];
            dv_negy_reg[k+1] <= dv_negy_reg[k];
            dv_dm_reg[k+1]   <= dv_dm_reg[k];
            dv_rx_reg[k+1]   <= gex_c[k] ? XW'(trx_c[k] - {1'b0, dv_dm_reg[k]})
                                         : XW'(trx_c[k]);
            dv_ry_reg[k+1]   <= gey_c[k] ? XW'(try_c[k] - {1'b0, dv_dm_reg[k]})
                                         : XW'(try_c[k]);
            dv_lx_reg[k+1]   <= dv_lx_reg[k] << 1;
            dv_ly_reg[k+1]   <= dv_ly_reg[k] << 1;
            dv_qx_reg[k+1]   <= {dv_qx_reg[k][QW-2:0], gex_c[k]};
            dv_qy_reg[k+1]   <= {dv_qy_reg[k][QW-2:0], gey_c[k]};
        end
    end

    // Output stage: sign, saturation to the output range, zero without a hit.
    function automatic logic signed [OW-1:0] finish(input logic [QW-1:0] q, input logic neg);
        logic signed [EW-1:0] e;
        logic signed [OW-1:0] r;
        e = neg ? -$signed(EW'(q)) : $signed(EW'(q));
        if (e > $signed(EW'({1'b0, {(OW-1){1'b1}}}))) r = {1'b0, {(OW-1){1'b1}}};
        else if (e < -$signed(EW'({1'b1, {(OW-1){1'b0}}}))) r = {1'b1, {(OW-1){1'b0}}};
        else r = OW'(e);
        return r;
    endfunction

    logic done_reg, hit_reg;
    logic [1:0] outcome_reg;
    logic signed [OW-1:0] point_x_reg, point_y_reg;
    logic fin_hit_c;

    assign fin_hit_c = dv_outc_reg[QW] == sip_pkg::OUTC_HIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= fin_hit_c;
        outcome_reg <= dv_outc_reg[QW];
        point_x_reg <= fin_hit_c ? finish(dv_qx_reg[QW], dv_negx_reg[QW]) : '0;
        point_y_reg <= fin_hit_c ? finish(dv_qy_reg[QW], dv_negy_reg[QW]) : '0;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign outcome = outcome_reg;
    assign point_x = point_x_reg;
    assign point_y = point_y_reg;

endmodule
